@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the rate limiter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property with asynchronous reset disable.
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/gcra_pkg.sv @@
// ----------------------------------------------------------------------------
// GCRA rate limiter package
// Widths, codes and the records passed between the pipeline stages.
// ----------------------------------------------------------------------------
package gcra_pkg;

	localparam int TIME_W     = 63;
	localparam int INTERVAL_W = 30;
	localparam int BURST_W    = 32;
	localparam int PROD_W     = INTERVAL_W + BURST_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int STATUS_W   = 2;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [STATUS_W-1:0] STATUS_ALLOWED      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_WAIT         = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INSUFFICIENT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 1'd1;

	typedef logic [TIME_W-1:0] time_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] interval;
		logic [BURST_W-1:0]    burst;
		logic [PROD_W-1:0]     tol;
	} cfg_t;

	typedef struct packed {
		logic               peek;
		time_t              now;
		logic [BURST_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic              peek;
		logic              zero;
		logic              over;
		time_t             now;
		logic [PROD_W-1:0] incr;
		logic [PROD_W-1:0] tol;
		logic [TIME_W:0]   now_tol;
	} prep_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		time_t               ready_ns;
		time_t               wait_ns;
	} res_t;

endpackage

@@ src/gcra_cfg.sv @@
// ----------------------------------------------------------------------------
// GCRA configuration registers
// Holds the emission interval and burst limit and their product, the delay
// tolerance.
// ----------------------------------------------------------------------------
module gcra_cfg
	import gcra_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [INTERVAL_W-1:0] interval_q;
	logic [BURST_W-1:0]    burst_q;
	logic [PROD_W-1:0]     tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_W'(1);
			burst_q    <= BURST_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_BURST:    burst_q    <= cfg_data[BURST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= PROD_W'(1);
		end else begin
			tol_q <= PROD_W'(interval_q) * PROD_W'(burst_q);
		end
	end

	assign cfg.interval = interval_q;
	assign cfg.burst    = burst_q;
	assign cfg.tol      = tol_q;

endmodule

@@ src/gcra_prep.sv @@
// ----------------------------------------------------------------------------
// GCRA request preparation stage
// Classifies the amount, forms the TAT increment and the sum of the current
// time and the tolerance, none of which depend on the stored TAT.
// ----------------------------------------------------------------------------
module gcra_prep
	import gcra_pkg::*;
(
	input  logic  clk,
	input  logic  load,
	input  req_t  req,
	input  cfg_t  cfg,
	output prep_t prep_s2
);

	prep_t prep_d;

	always_comb begin
		prep_d.peek    = req.peek;
		prep_d.zero    = (req.amount == '0);
		prep_d.over    = (req.amount > cfg.burst);
		prep_d.now     = req.now;
		prep_d.incr    = PROD_W'(cfg.interval) * PROD_W'(req.amount);
		prep_d.tol     = cfg.tol;
		prep_d.now_tol = {1'b0, req.now} + (TIME_W + 1)'(cfg.tol);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prep_s2 <= prep_d;
		end
	end

endmodule

@@ src/gcra_core.sv @@
// ----------------------------------------------------------------------------
// GCRA decision stage
// Keeps the theoretical arrival time, decides allow, wait or refuse and
// registers the result.
// ----------------------------------------------------------------------------
module gcra_core
	import gcra_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  prep_t prep,
	output res_t  res
);

	`include "assert_macros.svh"

	time_t           tat_q;
	time_t           base;
	logic [TIME_W:0] sum;
	time_t           cand;
	logic [TIME_W:0] wait_diff;
	time_t           earliest;
	logic            must_wait;
	res_t            res_d;
	logic            update;
	res_t            res_q;

	always_comb begin
		base      = (tat_q > prep.now) ? tat_q : prep.now;
		sum       = {1'b0, base} + (TIME_W + 1)'(prep.incr);
		cand      = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		must_wait = ({1'b0, cand} > prep.now_tol);
		wait_diff = {1'b0, cand} - prep.now_tol;
		earliest  = cand - TIME_W'(prep.tol);

		res_d.status   = STATUS_ALLOWED;
		res_d.ready_ns = '0;
		res_d.wait_ns  = '0;
		update         = 1'b0;
		if (prep.zero) begin
			res_d.status = STATUS_ALLOWED;
		end else if (prep.over) begin
			res_d.status   = STATUS_INSUFFICIENT;
			res_d.ready_ns = TIME_MAX;
			res_d.wait_ns  = TIME_MAX;
		end else if (must_wait) begin
			res_d.status   = STATUS_WAIT;
			res_d.ready_ns = earliest;
			res_d.wait_ns  = wait_diff[TIME_W-1:0];
		end else begin
			update = !prep.peek;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tat_q <= '0;
		end else if (load && update) begin
			tat_q <= cand;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

	`ASSERT_CHK(a_tat_hold, clk, arst_n, !load |=> $stable(tat_q),
		"TAT changed without a decision")
	`ASSERT_CHK(a_tat_grows, clk, arst_n, load && update |=> tat_q >= $past(prep.now),
		"TAT fell behind the request time")

endmodule

@@ src/gcra_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// GCRA rate limiter
// Generic cell rate algorithm over a single theoretical arrival time.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the mode (acquire or peek),
// s_tdata the current time and the amount. Each request gives exactly one
// result on the m_ stream: m_tuser carries the status, m_tdata the ready time
// and the wait duration. Results leave in request order.
// The user must write the emission interval and burst limit through the cfg_
// port only while no request is in flight; the block does not enforce this.
// The new tolerance is registered in the cycle after the interval or burst
// register takes the write. An input transfer loads the input register, the
// prep register takes the increment multiply and tolerance sum, and the
// decision stage updates the TAT and loads the result register.
// Throughput is one request per cycle while the receiver does not stall, set
// by the TAT update loop in the decision stage.
// Reset clears the TAT to zero and sets interval and burst limit to one.
// When the receiver stalls, the result holds and the stages fill up; s_tready
// drops only once all three stages hold a request.
// ----------------------------------------------------------------------------
module gcra_rate_limiter
	import gcra_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [95:0]           s_tdata,  // now_ns[62:0], amount[94:63], zero
	input  logic [0:0]            s_tuser,  // mode[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [127:0]          m_tdata,  // ready_at_ns[62:0], wait_ns[125:63], zero
	output logic [STATUS_W-1:0]   m_tuser   // status[1:0]
);

	`include "assert_macros.svh"

	cfg_t  cfg;
	req_t  req_s1;
	prep_t prep_s2;
	res_t  res;
	logic  v_s1_q;
	logic  v_s2_q;
	logic  v_out_q;
	logic  adv_out;
	logic  ld2;
	logic  ld1;

	assign adv_out  = !v_out_q || m_tready;
	assign ld2      = !v_s2_q || adv_out;
	assign ld1      = !v_s1_q || ld2;
	assign s_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1_q <= s_tvalid;
			end
			if (ld2) begin
				v_s2_q <= v_s1_q;
			end
			if (adv_out) begin
				v_out_q <= v_s2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && s_tvalid) begin
			req_s1.peek   <= s_tuser[0];
			req_s1.now    <= s_tdata[TIME_W-1:0];
			req_s1.amount <= s_tdata[TIME_W+BURST_W-1:TIME_W];
		end
	end

	gcra_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gcra_prep u_prep (
		.clk     (clk),
		.load    (ld2 && v_s1_q),
		.req     (req_s1),
		.cfg     (cfg),
		.prep_s2 (prep_s2)
	);

	gcra_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv_out && v_s2_q),
		.prep   (prep_s2),
		.res    (res)
	);

	assign m_tvalid = v_out_q;
	assign m_tuser  = res.status;
	assign m_tdata  = {2'b00, res.wait_ns, res.ready_ns};

	`ASSERT_ALWAYS(a_ready_when_room, clk,
		!s_tready |-> v_s1_q && v_s2_q && v_out_q,
		"input stalled while a stage was free")
	`ASSERT_CHK(a_refused_max, clk, arst_n,
		m_tvalid && m_tuser == STATUS_INSUFFICIENT |->
			res.ready_ns == TIME_MAX && res.wait_ns == TIME_MAX,
		"refused request without saturated times")
	`ASSERT_CHK(a_allowed_zero, clk, arst_n,
		m_tvalid && m_tuser == STATUS_ALLOWED |-> res.ready_ns == '0 && res.wait_ns == '0,
		"allowed request with nonzero times")
	`ASSERT_CHK(a_wait_positive, clk, arst_n,
		m_tvalid && m_tuser == STATUS_WAIT |-> res.wait_ns != '0 && res.ready_ns >= res.wait_ns,
		"wait result with inconsistent times")

endmodule

@@ verif/gcra_rate_limiter_tb.sv @@
// ----------------------------------------------------------------------------
// GCRA rate limiter testbench
// Runs directed requests (reset values, zero burst, zero interval, field
// extremes, saturation), a long receiver hold-off, and random traffic aimed
// around the tracked arrival time under several rate settings. Each result
// transfer is checked against a local model of the algorithm.
// ----------------------------------------------------------------------------
module gcra_rate_limiter_tb;
	import gcra_pkg::*;

	localparam int                    RESET_CYCLES    = 12;
	localparam int                    SETTLE_CYCLES   = 6;
	localparam int unsigned           STALL_LIMIT     = 4000;
	localparam int                    PHASE_ITEMS     = 65;
	localparam logic [CFG_DATA_W-1:0] INTERVAL_MAX_NS = 32'd1000000000;
	localparam logic [BURST_W-1:0]    BURST_MAX       = 32'hFFFF_FFFF;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_INTERVAL;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [95:0]           s_tdata   = '0;
	logic [0:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [127:0]          m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	logic [INTERVAL_W-1:0] rate_interval = 1;
	logic [BURST_W-1:0]    rate_burst    = 1;
	time_t                 tat           = '0;
	res_t                  pending_verdicts[$];

	int unsigned fail_cnt    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned rx_hold_req = 0;
	int unsigned rx_stall    = 0;
	bit          tx_steady   = 1'b0;
	bit          rx_steady   = 1'b0;

	gcra_rate_limiter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	function automatic res_t gcra_decide(input logic peek, input time_t now,
			input logic [BURST_W-1:0] amount);
		logic [63:0] step_ns;
		logic [63:0] tol_ns;
		logic [63:0] base;
		logic [63:0] cand;
		logic [63:0] earliest;
		res_t        verdict;
		verdict = '0;
		if (amount == '0) begin
			return verdict;
		end
		if (amount > rate_burst) begin
			verdict.status   = STATUS_INSUFFICIENT;
			verdict.ready_ns = TIME_MAX;
			verdict.wait_ns  = TIME_MAX;
			return verdict;
		end
		step_ns = rate_interval;
		step_ns = step_ns * amount;
		tol_ns  = rate_interval;
		tol_ns  = tol_ns * rate_burst;
		base    = (tat > now) ? tat : now;
		cand    = base + step_ns;
		if (cand > TIME_MAX) begin
			cand = TIME_MAX;
		end
		if (cand > tol_ns) begin
			earliest = cand - tol_ns;
			if (earliest > now) begin
				verdict.status   = STATUS_WAIT;
				verdict.ready_ns = earliest[TIME_W-1:0];
				verdict.wait_ns  = earliest[TIME_W-1:0] - now;
				return verdict;
			end
		end
		if (!peek) begin
			tat = cand[TIME_W-1:0];
		end
		return verdict;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [63:0] rnd_upto(input logic [63:0] hi);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (hi == '1) begin
			return v;
		end
		return v % (hi + 64'd1);
	endfunction

	function automatic logic [BURST_W-1:0] pick_amount();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8 || rate_burst == '0) begin
			return '0;
		end
		if (r < 16 && rate_burst != BURST_MAX) begin
			return $urandom_range(rate_burst + 1, BURST_MAX);
		end
		if (r < 60 || rate_burst <= 16) begin
			return $urandom_range(1, (rate_burst > 16) ? 16 : rate_burst);
		end
		return $urandom_range(1, rate_burst);
	endfunction

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (m_tvalid && m_tready) begin
			got.status   = m_tuser;
			got.ready_ns = m_tdata[62:0];
			got.wait_ns  = m_tdata[125:63];
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result transfer, status %0d", got.status);
				fail_cnt++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_cnt++;
				end
				if (got.ready_ns !== want.ready_ns) begin
					$error("ready_at_ns: expected %0d, got %0d", want.ready_ns, got.ready_ns);
					fail_cnt++;
				end
				if (got.wait_ns !== want.wait_ns) begin
					$error("wait_ns: expected %0d, got %0d", want.wait_ns, got.wait_ns);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_stall    = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_stall != 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
			if (!rx_steady && $urandom_range(99) < 25) begin
				rx_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_req(input logic peek, input time_t now,
			input logic [BURST_W-1:0] amount);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= peek;
		s_tdata  <= {1'b0, amount, now};
		do begin
			@(posedge clk);
		end while (!(s_tvalid && s_tready));
		pending_verdicts.push_back(gcra_decide(peek, now, amount));
		gap = tx_steady ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		settle_pipeline();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_INTERVAL) begin
			rate_interval = value[INTERVAL_W-1:0];
		end else begin
			rate_burst = value;
		end
	endtask

	task automatic set_rates(input logic [CFG_DATA_W-1:0] interval_ns,
			input logic [CFG_DATA_W-1:0] burst);
		write_reg(CFG_INTERVAL, interval_ns);
		write_reg(CFG_BURST, burst);
	endtask

	// Most requests land near the arrival time, where the allow and wait
	// decisions meet; the rest are unrelated noise over the whole field range.
	task automatic send_random_req();
		logic [63:0]        tol_ns;
		logic [63:0]        x;
		logic [63:0]        now_w;
		logic [BURST_W-1:0] amount;
		int unsigned        r;
		tol_ns = rate_interval;
		tol_ns = tol_ns * rate_burst;
		r      = $urandom_range(99);
		if (r >= 85) begin
			now_w = rnd_upto(TIME_MAX);
			send_req($urandom_range(99) < 75, now_w[TIME_W-1:0], $urandom);
		end else begin
			amount = pick_amount();
			if (r < 60) begin
				x     = rnd_upto(2 * tol_ns + 2);
				now_w = (x > tat) ? 64'd0 : tat - x;
			end else begin
				x     = rnd_upto(tol_ns + 2);
				now_w = tat + x;
				if (now_w > TIME_MAX) begin
					now_w = TIME_MAX;
				end
			end
			send_req($urandom_range(99) < 25, now_w[TIME_W-1:0], amount);
		end
	endtask

	task automatic test_reset_defaults();
		send_req(1'b0, '0, 0);
		send_req(1'b0, '0, 1);
		send_req(1'b0, '0, 2);
		send_req(1'b0, '0, 1);
		send_req(1'b1, 63'd5, 1);
		send_req(1'b0, 63'd1, 1);
	endtask

	task automatic test_zero_burst();
		set_rates(3, 0);
		send_req(1'b0, 63'd10, 1);
		send_req(1'b1, 63'd10, 0);
		send_req(1'b0, 63'd10, BURST_MAX);
	endtask

	task automatic test_zero_interval();
		set_rates(0, 5);
		send_req(1'b0, '0, 3);
		send_req(1'b0, 63'd1000, 5);
		send_req(1'b0, 63'd1000, 6);
		send_req(1'b1, '0, 1);
	endtask

	// Saturation is probed in peek mode so the arrival time stays low.
	task automatic test_field_extremes();
		set_rates(INTERVAL_MAX_NS, BURST_MAX);
		send_req(1'b1, '0, BURST_MAX);
		send_req(1'b1, TIME_MAX, BURST_MAX);
		send_req(1'b1, TIME_MAX, 0);
		send_req(1'b0, '0, 1);
		set_rates(INTERVAL_MAX_NS, 1);
		send_req(1'b1, TIME_MAX - 63'd5, 1);
		send_req(1'b0, 63'd1000000000, 1);
		send_req(1'b0, '0, 1);
	endtask

	task automatic test_backpressure();
		set_rates(7, 8);
		rx_hold_req = 120;
		tx_steady   = 1'b1;
		repeat (30) send_random_req();
		tx_steady = 1'b0;
		settle_pipeline();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_rates(1, 1);
				1: set_rates($urandom_range(1, 1000), $urandom_range(1, 64));
				2: set_rates($urandom_range(1, 100000), $urandom_range(1, 4096));
				3: set_rates(1, BURST_MAX);
				4: set_rates(INTERVAL_MAX_NS, 1);
				5: set_rates($urandom_range(1, INTERVAL_MAX_NS), $urandom_range(1, 1000));
				6: set_rates(INTERVAL_MAX_NS, BURST_MAX);
				default: set_rates($urandom_range(1, INTERVAL_MAX_NS),
					$urandom_range(1, BURST_MAX));
			endcase
			tx_steady = (phase % 3 == 2);
			rx_steady = tx_steady;
			repeat (PHASE_ITEMS) send_random_req();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_zero_burst();
		test_zero_interval();
		test_field_extremes();
		test_backpressure();
		test_random_traffic();
		settle_pipeline();
		if (fail_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
